>>> design/spmd_pkg.sv
// Shared constants for the shortest-path matrix engine.
// No dependencies; imported by the top level, its port checker and the testbench.
package spmd_pkg;
    localparam int DEF_MAX_NODES   = 64;
    localparam int DEF_WEIGHT_BITS = 16;
    localparam int LABEL_BITS      = 6;
    localparam int FIELD_W_BITS    = 16;
    localparam int CFG_BITS        = 7;
    localparam int STATUS_BITS     = 2;
    localparam int IN_DATA_BITS    = 32;
    localparam int OUT_DATA_BITS   = 8;

    localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_SAME    = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_UNREACH = 2'd2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;
endpackage

>>> design/shortest_path_matrix_dijkstra_top.sv
// Shortest-path engine: adjacency matrix memory, per-node distance memory,
// path buffer and the sequencer. Depends on spmd_pkg.
//
// Usage:
//   The slave stream takes items: tuser = kind, tdata = from_node, to_node, weight.
//   A write item (kind 0) stores one edge cost in the matrix and gives no result.
//   A query item (kind 1) runs Dijkstra from from_node to to_node and then
//   sends the path labels from the start's successor to the goal on the master
//   stream, the final one with tlast. A status result (start equals goal, or
//   goal unreachable) is a single item with path_node zero and tlast set.
//   The configuration channel writes node_count; it is always ready.
//   Rate: one item is worked on at a time. A query settles nodes in turn until the
//   goal settles or none is left: each settled node costs one pass over its matrix
//   row, one entry per cycle through the matrix read port, with the distance
//   read-modify-write and minimum search pipelined behind it; the path walk
//   alternates S_WALK and S_WALK_WAIT for each path node, and the emission
//   alternates S_EMIT_RD and S_EMIT_LD. Reset: a clearing pass writes all
//   2^(2*clog2(MAX_NODES)) matrix entries (4096 by default) to zero; no item
//   is accepted meanwhile.
//   Stalls: the result is held in an output register until tready; the engine
//   waits and takes no new item until the query's results are loaded.
module shortest_path_matrix_dijkstra_top #(
    parameter int MAX_NODES   = spmd_pkg::DEF_MAX_NODES,
    parameter int WEIGHT_BITS = spmd_pkg::DEF_WEIGHT_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // from_node [5:0], to_node [11:6], weight [27:12], zero fill above
    input  logic [spmd_pkg::IN_DATA_BITS-1:0]  i_s_axis_tdata,
    // kind [0]
    input  logic                               i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // path_node [5:0], zero fill above
    output logic [spmd_pkg::OUT_DATA_BITS-1:0] o_m_axis_tdata,
    // status [1:0]
    output logic [spmd_pkg::STATUS_BITS-1:0]   o_m_axis_tuser,
    output logic                               o_m_axis_tlast,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [spmd_pkg::CFG_BITS-1:0]      i_cfg_data
);
    import spmd_pkg::*;

    localparam int IW    = $clog2(MAX_NODES);
    localparam int NCW   = $clog2(MAX_NODES + 1);
    localparam int AW    = 2 * IW;
    localparam int DW    = WEIGHT_BITS + IW;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_RELAX, S_WALK, S_WALK_WAIT, S_EMIT_RD, S_EMIT_LD, S_STAT
    } t_state;

    t_state r_state;

    logic [CFG_BITS-1:0]    r_node_count;
    logic [AW-1:0]          r_clr_cnt;
    logic [NCW-1:0]         r_n;
    logic [IW-1:0]          r_a, r_b;
    logic [MAX_NODES-1:0]   r_reached, r_settled;
    logic [IW-1:0]          r_pick;
    logic [DW-1:0]          r_pick_dist;
    logic [IW-1:0]          r_i;
    logic                   r_issue;
    logic                   r_d1_valid, r_d1_last;
    logic [IW-1:0]          r_d1_idx;
    logic                   r_s2_valid, r_s2_last, r_s2_cand;
    logic [IW-1:0]          r_s2_idx;
    logic [DW-1:0]          r_s2_dist;
    logic                   r_have;
    logic [IW-1:0]          r_best_idx;
    logic [DW-1:0]          r_best;
    logic [IW-1:0]          r_cur;
    logic [IW-1:0]          r_len;
    logic [STATUS_BITS-1:0] r_stat;
    logic                   r_out_valid, r_out_last;
    logic [LABEL_BITS-1:0]  r_out_node;
    logic [STATUS_BITS-1:0] r_out_status;

    // Memories
    logic [WEIGHT_BITS-1:0] edge_mem [DEPTH];
    logic [WEIGHT_BITS-1:0] r_edge_rdata;
    logic [IW+DW-1:0]       node_mem [MAX_NODES];
    logic [IW+DW-1:0]       r_node_rdata;
    logic [IW-1:0]          path_mem [MAX_NODES];
    logic [IW-1:0]          r_path_rdata;

    // Input fields
    logic [LABEL_BITS-1:0]   in_from, in_to;
    logic [FIELD_W_BITS-1:0] in_weight;
    logic                    in_acc;
    logic [IW-1:0]           a_idx, b_idx;
    logic [NCW-1:0]          eff_n;
    logic                    out_free;

    assign in_from   = i_s_axis_tdata[LABEL_BITS-1:0];
    assign in_to     = i_s_axis_tdata[2*LABEL_BITS-1:LABEL_BITS];
    assign in_weight = i_s_axis_tdata[2*LABEL_BITS+FIELD_W_BITS-1:2*LABEL_BITS];
    assign in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign a_idx     = IW'(in_from);
    assign b_idx     = IW'(in_to);
    assign out_free  = !r_out_valid || i_m_axis_tready;

    always_comb begin
        if (r_node_count == '0) begin
            eff_n = NCW'(1);
        end else if (int'(r_node_count) > MAX_NODES) begin
            eff_n = NCW'(MAX_NODES);
        end else begin
            eff_n = NCW'(r_node_count);
        end
    end

    // Relaxation stage: matrix weight and stored distance of node r_d1_idx.
    logic [WEIGHT_BITS-1:0] w1;
    logic [DW-1:0]          dist1, nd1, newd1;
    logic                   upd1, cand1;

    always_comb begin
        w1    = r_edge_rdata;
        dist1 = r_node_rdata[DW-1:0];
        nd1   = r_pick_dist + DW'(w1);
        upd1  = r_d1_valid && (w1 != '0) && !r_settled[r_d1_idx]
                && (!r_reached[r_d1_idx] || nd1 < dist1);
        newd1 = upd1 ? nd1 : dist1;
        cand1 = (r_reached[r_d1_idx] || upd1) && !r_settled[r_d1_idx];
    end

    // Minimum stage: lowest distance, lowest label on ties.
    logic           better2, fin_have;
    logic [IW-1:0]  fin_idx;
    logic [DW-1:0]  fin_dist;

    always_comb begin
        better2  = r_s2_valid && r_s2_cand && (!r_have || r_s2_dist < r_best);
        fin_have = r_have || better2;
        fin_idx  = better2 ? r_s2_idx : r_best_idx;
        fin_dist = better2 ? r_s2_dist : r_best;
    end

    // Matrix memory: one write port shared by the clearing pass and edge writes.
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            edge_mem[r_clr_cnt] <= '0;
        end else if (in_acc && i_s_axis_tuser == KIND_WRITE
                     && int'(in_from) < MAX_NODES && int'(in_to) < MAX_NODES) begin
            edge_mem[{a_idx, b_idx}] <= WEIGHT_BITS'(in_weight);
        end
        r_edge_rdata <= edge_mem[{r_pick, r_i}];
    end

    // Per-node memory: {predecessor, distance}.
    always_ff @(posedge i_clk) begin
        if (upd1) begin
            node_mem[r_d1_idx] <= {r_pick, nd1};
        end
        r_node_rdata <= node_mem[(r_state == S_RELAX) ? r_i : r_cur];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WALK && r_cur != r_a) begin
            path_mem[r_len] <= r_cur;
        end
        r_path_rdata <= path_mem[r_len - IW'(1)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_cnt    <= '0;
            r_node_count <= CFG_BITS'(64);
            r_issue      <= 1'b0;
            r_d1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_have       <= 1'b0;
            r_reached    <= '0;
            r_settled    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_node_count <= i_cfg_data;
            end
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            // Pipeline behind the row read.
            r_d1_valid <= r_issue;
            r_d1_idx   <= r_i;
            r_d1_last  <= r_issue && (NCW'(r_i) == r_n - NCW'(1));
            r_s2_valid <= r_d1_valid;
            r_s2_last  <= r_d1_valid && r_d1_last;
            r_s2_idx   <= r_d1_idx;
            r_s2_cand  <= cand1;
            r_s2_dist  <= newd1;
            if (upd1) begin
                r_reached[r_d1_idx] <= 1'b1;
            end
            if (r_s2_valid) begin
                r_have     <= fin_have;
                r_best_idx <= fin_idx;
                r_best     <= fin_dist;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + AW'(1);
                    if (r_clr_cnt == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc && i_s_axis_tuser == KIND_QUERY) begin
                        r_a <= a_idx;
                        r_b <= b_idx;
                        r_n <= eff_n;
                        if (NCW'(in_from) >= eff_n || NCW'(in_to) >= eff_n
                            || int'(in_from) >= MAX_NODES || int'(in_to) >= MAX_NODES) begin
                            r_stat  <= ST_UNREACH;
                            r_state <= S_STAT;
                        end else if (in_from == in_to) begin
                            r_stat  <= ST_SAME;
                            r_state <= S_STAT;
                        end else begin
                            r_reached        <= '0;
                            r_settled        <= '0;
                            r_reached[a_idx] <= 1'b1;
                            r_settled[a_idx] <= 1'b1;
                            r_pick           <= a_idx;
                            r_pick_dist      <= '0;
                            r_i              <= '0;
                            r_issue          <= 1'b1;
                            r_have           <= 1'b0;
                            r_state          <= S_RELAX;
                        end
                    end
                end
                S_RELAX: begin
                    if (r_issue) begin
                        r_i <= r_i + IW'(1);
                        if (NCW'(r_i) == r_n - NCW'(1)) begin
                            r_issue <= 1'b0;
                        end
                    end
                    if (r_s2_valid && r_s2_last) begin
                        r_have <= 1'b0;
                        if (!fin_have) begin
                            r_stat  <= ST_UNREACH;
                            r_state <= S_STAT;
                        end else if (fin_idx == r_b) begin
                            r_cur   <= r_b;
                            r_len   <= '0;
                            r_state <= S_WALK;
                        end else begin
                            r_settled[fin_idx] <= 1'b1;
                            r_pick      <= fin_idx;
                            r_pick_dist <= fin_dist;
                            r_i         <= '0;
                            r_issue     <= 1'b1;
                        end
                    end
                end
                S_WALK: begin
                    if (r_cur == r_a) begin
                        r_state <= S_EMIT_RD;
                    end else begin
                        r_len   <= r_len + IW'(1);
                        r_state <= S_WALK_WAIT;
                    end
                end
                S_WALK_WAIT: begin
                    r_cur   <= r_node_rdata[IW+DW-1:DW];
                    r_state <= S_WALK;
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_LD;
                end
                S_EMIT_LD: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_node   <= LABEL_BITS'(r_path_rdata);
                        r_out_status <= ST_OK;
                        r_out_last   <= (r_len == IW'(1));
                        r_len        <= r_len - IW'(1);
                        r_state      <= (r_len == IW'(1)) ? S_IDLE : S_EMIT_RD;
                    end
                end
                S_STAT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_node   <= '0;
                        r_out_status <= r_stat;
                        r_out_last   <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_DATA_BITS'(r_out_node);
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;
endmodule

>>> design/spmd_chk.sv
// Port-level checker for the shortest-path engine, bound to the top level.
// Depends on spmd_pkg and shortest_path_matrix_dijkstra_top.
module spmd_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_axis_tvalid,
    input logic                               o_s_axis_tready,
    input logic [spmd_pkg::IN_DATA_BITS-1:0]  i_s_axis_tdata,
    input logic                               i_s_axis_tuser,
    input logic                               o_m_axis_tvalid,
    input logic                               i_m_axis_tready,
    input logic [spmd_pkg::OUT_DATA_BITS-1:0] o_m_axis_tdata,
    input logic [spmd_pkg::STATUS_BITS-1:0]   o_m_axis_tuser,
    input logic                               o_m_axis_tlast,
    input logic                               i_cfg_valid,
    input logic                               o_cfg_ready,
    input logic [spmd_pkg::CFG_BITS-1:0]      i_cfg_data
);
    import spmd_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid
            && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser == ST_OK || o_m_axis_tuser == ST_SAME
            || o_m_axis_tuser == ST_UNREACH))
        else $error("bad status code");

    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != ST_OK |-> o_m_axis_tlast && o_m_axis_tdata == '0)
        else $error("status result not a lone zero item");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && !o_s_axis_tready)
        else $error("activity right after reset");
endmodule

bind shortest_path_matrix_dijkstra_top spmd_chk u_spmd_chk (.*);

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for shortest_path_matrix_dijkstra_top: edge writes and
// path queries go in on the slave stream; path labels are checked against a local predictor.
// Depends on spmd_pkg and the top level only.
module tb;
    import spmd_pkg::*;

    localparam int NODES = DEF_MAX_NODES;

    typedef struct packed {
        logic [LABEL_BITS-1:0]  node;
        logic [STATUS_BITS-1:0] status;
        logic                   last;
    } t_path_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [IN_DATA_BITS-1:0] i_s_axis_tdata = '0;
    logic        i_s_axis_tuser = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] o_m_axis_tdata;
    logic [STATUS_BITS-1:0]   o_m_axis_tuser;
    logic        o_m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_BITS-1:0] i_cfg_data = '0;

    // Local copy of the graph and register.
    logic [15:0] graph_w [NODES*NODES];
    int unsigned node_limit;
    t_path_item  expected_path[$];
    int          mismatch_count = 0;
    int          burst_left = 0;
    bit          rx_stall_on = 1'b1;

    shortest_path_matrix_dijkstra_top dut (.*);

    always #5 i_clk = ~i_clk;

    initial begin
        #60000000;
        $display("shortest_path_matrix_dijkstra_top verification failed");
        $finish;
    end

    // Receiver stalls in its own on/off pattern.
    always @(negedge i_clk) begin
        if (!rx_stall_on) i_m_axis_tready <= 1'b1;
        else i_m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge i_clk) begin
        t_path_item got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.node = o_m_axis_tdata[LABEL_BITS-1:0];
            got.status = o_m_axis_tuser;
            got.last = o_m_axis_tlast;
            if (expected_path.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result node=%0d st=%0d last=%0b",
                             got.node, got.status, got.last);
            end else begin
                want = expected_path.pop_front();
                if (got !== want || o_m_axis_tdata[OUT_DATA_BITS-1:LABEL_BITS] !== '0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch exp node=%0d st=%0d last=%0b",
                                  " got node=%0d st=%0d last=%0b"},
                                 want.node, want.status, want.last,
                                 got.node, got.status, got.last);
                end
            end
        end
    end

    function automatic void push_status(logic [STATUS_BITS-1:0] st);
        t_path_item r;
        r.node = '0;
        r.status = st;
        r.last = 1'b1;
        expected_path = {expected_path, r};
    endfunction

    // Array Dijkstra, lowest label wins ties, stops once the goal settles.
    function automatic void predict_path(int unsigned src, int unsigned dst);
        longint unsigned node_dist [NODES];
        int unsigned pred [NODES];
        bit reached [NODES];
        bit settled [NODES];
        int unsigned hops [NODES];
        int unsigned n, pick, len, cur;
        longint unsigned nd;
        bit have, found;
        t_path_item r;
        n = (node_limit < 1) ? 1 : (node_limit > NODES ? NODES : node_limit);
        if (src >= n || dst >= n) begin
            push_status(ST_UNREACH);
            return;
        end
        if (src == dst) begin
            push_status(ST_SAME);
            return;
        end
        for (int i = 0; i < NODES; i++) begin
            node_dist[i] = 0; pred[i] = 0; reached[i] = 0; settled[i] = 0;
        end
        reached[src] = 1;
        found = 0;
        forever begin
            have = 0; pick = 0;
            for (int i = 0; i < n; i++)
                if (reached[i] && !settled[i] && (!have || node_dist[i] < node_dist[pick])) begin
                    pick = i; have = 1;
                end
            if (!have) break;
            settled[pick] = 1;
            if (pick == dst) begin found = 1; break; end
            for (int i = 0; i < n; i++)
                if (graph_w[pick*NODES+i] != 0) begin
                    nd = node_dist[pick] + graph_w[pick*NODES+i];
                    if (!reached[i] || nd < node_dist[i]) begin
                        reached[i] = 1; node_dist[i] = nd; pred[i] = pick;
                    end
                end
        end
        if (!found) begin
            push_status(ST_UNREACH);
            return;
        end
        len = 0; cur = dst;
        while (cur != src && len < n) begin
            hops[len++] = cur;
            cur = pred[cur];
        end
        for (int i = 0; i < len; i++) begin
            r.node = hops[len-1-i];
            r.status = ST_OK;
            r.last = (i + 1 == len);
            expected_path = {expected_path, r};
        end
    endfunction

    // Within a burst tvalid stays high from one item to the next.
    task automatic send_item(bit kind, int unsigned a, int unsigned b, int unsigned w);
        if (burst_left == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= kind;
        i_s_axis_tdata <= {4'b0, w[15:0], b[5:0], a[5:0]};
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (kind == KIND_WRITE) graph_w[a*NODES+b] = w[15:0];
        else predict_path(a, b);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (expected_path.size() != 0) @(negedge i_clk);
        // A trailing edge write may still be in flight.
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_node_count(int unsigned value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value[CFG_BITS-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        node_limit = value & 7'h7f;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        set_node_count(64);
        send_item(KIND_QUERY, 5, 5, 0);          // start equals goal
        send_item(KIND_QUERY, 0, 63, 16'hffff);  // no edges: unreachable
        send_item(KIND_WRITE, 0, 1, 16'hffff);
        send_item(KIND_WRITE, 1, 63, 16'hffff);
        send_item(KIND_WRITE, 0, 2, 1);
        send_item(KIND_WRITE, 2, 63, 16'h0001);
        send_item(KIND_WRITE, 63, 0, 16'haaaa);
        send_item(KIND_WRITE, 3, 3, 16'h5555);
        send_item(KIND_QUERY, 0, 63, 0);
        // Equal-cost routes: the lower label settles first.
        send_item(KIND_WRITE, 0, 4, 2);
        send_item(KIND_WRITE, 4, 5, 2);
        send_item(KIND_WRITE, 2, 5, 3);
        send_item(KIND_QUERY, 0, 5, 0);
        send_item(KIND_WRITE, 2, 63, 0);         // remove an edge
        send_item(KIND_QUERY, 0, 63, 0);
        send_item(KIND_QUERY, 63, 5, 0);
        set_node_count(8);
        send_item(KIND_QUERY, 0, 63, 0);         // goal above node count
        send_item(KIND_QUERY, 40, 1, 0);         // start above node count
        send_item(KIND_QUERY, 0, 5, 0);
        set_node_count(0);                       // saturates to one node
        send_item(KIND_QUERY, 0, 0, 0);
        send_item(KIND_QUERY, 0, 1, 0);
        set_node_count(127);
        send_item(KIND_QUERY, 0, 5, 0);
    endtask

    // Random writes and queries over the first n nodes; a small n makes most queries find multi-hop paths.
    task automatic test_random(int unsigned n, int count);
        int unsigned a, b;
        set_node_count(n);
        for (int k = 0; k < count; k++) begin
            a = $urandom_range(0, n - 1);
            b = $urandom_range(0, n - 1);
            if ($urandom_range(0, 9) < 6)
                send_item(KIND_WRITE, a, b,
                          ($urandom_range(0, 7) == 0) ? 0 :
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                      : $urandom_range(1, 20));
            else if ($urandom_range(0, 15) == 0)
                send_item(KIND_QUERY, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
            else
                send_item(KIND_QUERY, a, b, $urandom_range(0, 65535));
        end
    endtask

    task automatic test_quiet_receiver();
        rx_stall_on = 1'b0;
        test_random(64, 20);
        rx_stall_on = 1'b1;
    endtask

    initial begin
        for (int i = 0; i < NODES*NODES; i++) graph_w[i] = '0;
        node_limit = 64;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(12, 40);
        test_random(64, 30);
        test_quiet_receiver();
        test_random(3, 30);
        drain_results();
        if (mismatch_count == 0)
            $display("shortest_path_matrix_dijkstra_top verification clean");
        else
            $display("shortest_path_matrix_dijkstra_top verification failed");
        $finish;
    end
endmodule
